[src/tis_pkg.sv]
// package: trie sizes, row layout, request and status codes, transaction structs
package tis_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int ALPHABET = 26;
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int FREE_W = NODE_W + 1;
	localparam int LETTER_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam logic [7:0] FIRST_LETTER = 8'h61;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_PREFIX = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_BADCHAR = 2'd2;

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		logic                             end_mark;
		logic [ALPHABET-1:0][NODE_W-1:0] child;
	} row_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_byte;
		logic       last_char;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [1:0] status;
	} rsp_t;

endpackage

[src/trie_insert_search_prefix_unit.sv]
// top level: prefix trie insert, exact search and prefix test over a node pool
//
// A word arrives one character per request transaction, the last one flagged by
// last_char; the request type is taken from the first character. Each trie node
// is one row of a single-port-read, single-port-write memory (registered read)
// holding all child pointers plus the end-of-word mark. A character that walks
// the trie is accepted with the read of the current node's row, then goes through
// the walk step, which writes the row back when an insert allocates a child. A
// character after an error, or after a search path went missing, skips the read.
// The final character of a word adds the mark step on the reached node's row
// (insert sets its end mark, search reads it; prefix skips this) and the done
// step that hands the result to the response register. The response register
// lets the next word start while a result still waits. After reset the block
// clears all NODE_COUNT (1024) node rows, one row a cycle, with req_ready low.
module trie_insert_search_prefix_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tis_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tis_pkg::rsp_t rsp
);
	import tis_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_MARK  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	node_t clr_addr_q;

	// word context
	node_t cur_q;
	logic [FREE_W-1:0] free_q;
	logic [1:0] kind_q;
	logic in_word_q;
	logic miss_q;
	logic [1:0] err_q;

	// payload of the character in flight and the pending result
	logic [LETTER_W-1:0] letter_q;
	logic last_q;
	logic found_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// memory ports
	logic wr_en;
	node_t wr_addr;
	row_t wr_row;
	logic rd_en;
	node_t rd_addr;
	row_t rd_row;

	logic accept;
	logic [1:0] eff_kind;
	logic [1:0] eff_err;
	logic eff_miss;
	node_t eff_cur;
	logic bad_char;
	logic need_access;

	node_t nxt;
	node_t walk_cur;
	logic [1:0] walk_err;
	logic walk_miss;
	logic walk_alloc;
	logic walk_mark;
	logic rsp_free;

	tis_row_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row)
	);

	assign req_ready = (state_q == ST_IDLE);
	assign accept = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// word start: take the type and reset the walk on the first character
	always_comb begin
		if (in_word_q) begin
			eff_kind = kind_q;
			eff_err = err_q;
			eff_miss = miss_q;
			eff_cur = cur_q;
		end else begin
			eff_kind = (req.req_type == REQ_UNUSED) ? REQ_PREFIX : req.req_type;
			eff_err = STATUS_OK;
			eff_miss = 1'b0;
			eff_cur = '0;
		end
	end

	assign bad_char = (req.char_byte < FIRST_LETTER) ||
		({1'b0, req.char_byte} >= 9'(FIRST_LETTER + ALPHABET));
	assign need_access = (eff_err == STATUS_OK) && !bad_char &&
		!((eff_kind != REQ_INSERT) && eff_miss);

	// walk step on the row read for the current node
	always_comb begin
		nxt = rd_row.child[letter_q];
		walk_cur = cur_q;
		walk_err = err_q;
		walk_miss = miss_q;
		walk_alloc = 1'b0;
		if (kind_q == REQ_INSERT) begin
			if (nxt == '0) begin
				if (free_q == FREE_W'(NODE_COUNT)) begin
					walk_err = STATUS_FULL;
				end else begin
					walk_alloc = 1'b1;
					walk_cur = free_q[NODE_W-1:0];
				end
			end else begin
				walk_cur = nxt;
			end
		end else begin
			if (nxt == '0) begin
				walk_miss = 1'b1;
			end else begin
				walk_cur = nxt;
			end
		end
	end

	// last character that still needs the end mark of the reached node
	assign walk_mark = last_q && (walk_err == STATUS_OK) && !walk_miss &&
		(kind_q != REQ_PREFIX);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = eff_cur;
		if (state_q == ST_IDLE) begin
			rd_en = accept && need_access;
		end else if (state_q == ST_WALK) begin
			rd_en = walk_mark;
			rd_addr = walk_cur;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = cur_q;
		wr_row = rd_row;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_addr_q;
				wr_row = '0;
			end
			ST_WALK: begin
				wr_en = walk_alloc;
				wr_row.child[letter_q] = free_q[NODE_W-1:0];
			end
			ST_MARK: begin
				wr_en = (kind_q == REQ_INSERT);
				wr_row.end_mark = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
			cur_q <= '0;
			free_q <= FREE_W'(1);
			kind_q <= REQ_INSERT;
			in_word_q <= 1'b0;
			miss_q <= 1'b0;
			err_q <= STATUS_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			// result register: loaded from the done state, emptied by the receiver
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == NODE_W'(NODE_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						kind_q <= eff_kind;
						cur_q <= eff_cur;
						miss_q <= eff_miss;
						in_word_q <= !req.last_char;
						err_q <= (eff_err == STATUS_OK && bad_char) ? STATUS_BADCHAR : eff_err;
						if (need_access) begin
							state_q <= ST_WALK;
						end else if (req.last_char) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					cur_q <= walk_cur;
					err_q <= walk_err;
					miss_q <= walk_miss;
					if (walk_alloc) begin
						free_q <= free_q + 1'b1;
					end
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (walk_mark) begin
						state_q <= ST_MARK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MARK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			letter_q <= LETTER_W'(req.char_byte - FIRST_LETTER);
			last_q <= req.last_char;
			found_q <= 1'b0;
		end
		if (state_q == ST_WALK) begin
			// prefix test ends here when the whole path exists
			found_q <= (walk_err == STATUS_OK) && !walk_miss && (kind_q == REQ_PREFIX);
		end
		if (state_q == ST_MARK) begin
			found_q <= (kind_q == REQ_INSERT) ? 1'b1 : rd_row.end_mark;
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_q.found <= found_q;
			rsp_q.status <= err_q;
		end
	end

endmodule

[src/tis_row_mem.sv]
// node row memory: one row per trie node, child pointers and end mark
module tis_row_mem (
	input  logic          clk,
	input  logic          wr_en,
	input  tis_pkg::node_t wr_addr,
	input  tis_pkg::row_t  wr_row,
	input  logic          rd_en,
	input  tis_pkg::node_t rd_addr,
	output tis_pkg::row_t  rd_row
);
	import tis_pkg::*;

	row_t mem [NODE_COUNT];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= mem[rd_addr];
		end
	end

endmodule

[src/tis_checker.sv]
// port checker for the trie unit and its bind to the top level
module tis_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input tis_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input tis_pkg::rsp_t rsp
);
	import tis_pkg::*;

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// any error status reports not found
	a_err_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != STATUS_OK) |-> !rsp.found)
		else $error("found set with error status");

	// status code stays in its defined range
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == STATUS_OK) || (rsp.status == STATUS_FULL) ||
			(rsp.status == STATUS_BADCHAR))
		else $error("undefined status code");

	// the final character of a word always occupies the unit for the next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.last_char |=> !req_ready)
		else $error("ready right after last character");

endmodule

bind trie_insert_search_prefix_unit tis_checker u_tis_checker (.*);

[sim/trie_insert_search_prefix_unit_tb.sv]
// testbench: prefix trie unit checked against a behavioral trie under random stalls
`timescale 1ns / 100ps

module trie_insert_search_prefix_unit_tb;
	import tis_pkg::*;

	localparam int IDLE_PCT = 27;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BANK = 256;
	localparam int MAXL = 24;
	localparam int FILL_LEN = 16;
	localparam int HOLD_AT = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	trie_insert_search_prefix_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// characters waiting to be offered, and results the trie walk has predicted
	req_t char_q[$];
	rsp_t verdict_q[$];

	// behavioral copy of the trie
	node_t               child_mem [NODE_COUNT*ALPHABET];
	logic                end_mem [NODE_COUNT];
	node_t               cur_node;
	logic [FREE_W-1:0]   free_ptr;
	logic [1:0]          word_kind;
	logic                mid_word;
	logic                path_gone;
	logic [1:0]          word_err;

	// words already inserted, reused to build searches that reach deep paths
	logic [7:0] bank_ch [0:BANK-1][0:MAXL-1];
	int         bank_len [0:BANK-1];
	int         bank_n = 0;
	logic [7:0] wbuf [0:MAXL-1];

	int   n_items = 0;
	int   n_rsp = 0;
	int   n_found = 0;
	int   n_full = 0;
	int   n_bad = 0;
	int   n_err = 0;
	int   cycle_count = 0;
	int   hold_left = 0;
	logic held = 1'b0;
	logic calm = 1'b0;
	logic req_taken = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one character through the trie; pushes the predicted result on the last character
	task automatic trie_walk(input req_t it);
		int unsigned slot;
		node_t       nxt;
		rsp_t        r;
		// request type is latched from the first character only, unused code acts as prefix
		if (!mid_word) begin
			word_kind = (it.req_type == REQ_UNUSED) ? REQ_PREFIX : it.req_type;
			cur_node = '0;
			path_gone = 1'b0;
			word_err = STATUS_OK;
			mid_word = 1'b1;
		end
		// after the first error the rest of the word leaves the trie alone
		if (word_err == STATUS_OK) begin
			if (it.char_byte < FIRST_LETTER ||
				it.char_byte >= FIRST_LETTER + ALPHABET) begin
				word_err = STATUS_BADCHAR;
			end else begin
				slot = cur_node * ALPHABET + (it.char_byte - FIRST_LETTER);
				nxt = child_mem[slot];
				if (word_kind == REQ_INSERT) begin
					if (nxt == '0) begin
						// allocate the next pool node, or flag the pool as exhausted
						if (free_ptr >= NODE_COUNT) begin
							word_err = STATUS_FULL;
						end else begin
							nxt = free_ptr[NODE_W-1:0];
							child_mem[slot] = nxt;
							free_ptr = free_ptr + 1'b1;
						end
					end
					if (word_err == STATUS_OK) cur_node = nxt;
				end else if (!path_gone) begin
					// search and prefix stop walking at the first absent child
					if (nxt == '0) path_gone = 1'b1;
					else cur_node = nxt;
				end
			end
		end
		if (it.last_char) begin
			r.status = word_err;
			r.found = 1'b0;
			if (word_err == STATUS_OK) begin
				case (word_kind)
					REQ_INSERT: begin
						end_mem[cur_node] = 1'b1;
						r.found = 1'b1;
					end
					REQ_SEARCH: r.found = !path_gone && end_mem[cur_node];
					default: r.found = !path_gone;
				endcase
			end
			verdict_q.push_back(r);
			mid_word = 1'b0;
		end
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] v;
		// half the letters come from a tiny subset so that paths are shared
		if ($urandom_range(1, 0) != 0) v = 8'(FIRST_LETTER + $urandom_range(3, 0));
		else v = 8'(FIRST_LETTER + $urandom_range(ALPHABET - 1, 0));
		return v;
	endfunction

	function automatic logic [7:0] pick_bad();
		logic [7:0] v;
		v = 8'($urandom_range(255, 0));
		// flipping the top bit moves a letter out of range
		if (v >= FIRST_LETTER && v < FIRST_LETTER + ALPHABET) v = v ^ 8'h80;
		return v;
	endfunction

	// queue wbuf[0..n-1] as one word; later characters carry a random, ignored type
	task automatic send_word(input logic [1:0] kind, input int n);
		req_t it;
		for (int i = 0; i < n; i++) begin
			it.req_type = (i == 0) ? kind : 2'($urandom_range(3, 0));
			it.char_byte = wbuf[i];
			it.last_char = (i == n - 1);
			char_q.push_back(it);
			n_items++;
		end
	endtask

	task automatic send_text(input logic [1:0] kind, input string s);
		for (int i = 0; i < s.len(); i++) wbuf[i] = s[i];
		send_word(kind, s.len());
	endtask

	task automatic keep_word(input int n);
		int slot;
		slot = (bank_n < BANK) ? bank_n : $urandom_range(BANK - 1, 0);
		for (int i = 0; i < n; i++) bank_ch[slot][i] = wbuf[i];
		bank_len[slot] = n;
		if (bank_n < BANK) bank_n++;
	endtask

	// mostly well-formed words on known paths, plus noise and broken words
	task automatic gen_mix(input int count);
		int         start;
		int         r;
		int         b;
		int         src_len;
		int         n_ch;
		logic [1:0] kind;
		start = n_items;
		while (n_items - start < count) begin
			r = $urandom_range(99, 0);
			src_len = 0;
			if (bank_n != 0 && $urandom_range(3, 0) != 0) begin
				b = $urandom_range(bank_n - 1, 0);
				src_len = bank_len[b];
				for (int i = 0; i < src_len; i++) wbuf[i] = bank_ch[b][i];
			end
			if (r < 35) begin
				kind = REQ_INSERT;
				n_ch = src_len + $urandom_range(4, 0);
			end else if (r < 80) begin
				kind = (r < 60) ? REQ_SEARCH :
					(($urandom_range(3, 0) == 0) ? REQ_UNUSED : REQ_PREFIX);
				case ($urandom_range(2, 0))
					0: n_ch = src_len;
					1: n_ch = $urandom_range((src_len > 0) ? src_len : 1, 1);
					default: n_ch = src_len + 1;
				endcase
			end else begin
				kind = 2'($urandom_range(3, 0));
				n_ch = src_len;
			end
			if (n_ch == 0) n_ch = $urandom_range(8, 1);
			if (n_ch > MAXL) n_ch = MAXL;
			for (int i = src_len; i < n_ch; i++) wbuf[i] = pick_letter();
			if (r >= 80 && r < 90) begin
				// noise: any byte anywhere
				for (int i = 0; i < n_ch; i++)
					if ($urandom_range(1, 0) != 0) wbuf[i] = 8'($urandom_range(255, 0));
			end else if (r >= 90) begin
				// broken word: one character out of range
				wbuf[$urandom_range(n_ch - 1, 0)] = pick_bad();
			end
			send_word(kind, n_ch);
			if (r < 35) keep_word(n_ch);
		end
	endtask

	// wait until every queued character went in and every result came back
	task automatic drain();
		while (char_q.size() != 0 || req_valid || verdict_q.size() != 0) @(posedge clk);
	endtask

	// request side: acceptance at the rising edge feeds the trie walk
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			trie_walk(req);
			req_taken = 1'b1;
		end
	end

	// request driver: payload changes at the falling edge only
	always @(negedge clk) begin : driver
		req_t nxt_item;
		if (arst_n && (!req_valid || req_taken)) begin
			if (char_q.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
				nxt_item = char_q.pop_front();
				req <= nxt_item;
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// response receiver: random stalls plus one long hold-off so the block backs up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held && n_rsp >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				held = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
			end
		end
	end

	// monitor: each result against the oldest prediction
	always @(posedge clk) begin : monitor
		rsp_t exp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: result with nothing expected, found %0b status %0d",
					$time, rsp.found, rsp.status);
				n_err++;
			end else begin
				exp = verdict_q.pop_front();
				if (rsp.found !== exp.found) begin
					$display("%0t: found mismatch, expected %0b got %0b",
						$time, exp.found, rsp.found);
					n_err++;
				end
				if (rsp.status !== exp.status) begin
					$display("%0t: status mismatch, expected %0d got %0d",
						$time, exp.status, rsp.status);
					n_err++;
				end
			end
			n_rsp++;
			if (rsp.found) n_found++;
			if (rsp.status == STATUS_FULL) n_full++;
			if (rsp.status == STATUS_BADCHAR) n_bad++;
			// a stretch of results with no idling on either side
			calm = (n_rsp >= 60 && n_rsp < 100);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, verdict_q.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		// trie state after reset
		for (int i = 0; i < NODE_COUNT * ALPHABET; i++) child_mem[i] = '0;
		for (int i = 0; i < NODE_COUNT; i++) end_mem[i] = 1'b0;
		cur_node = '0;
		free_ptr = FREE_W'(1);
		word_kind = REQ_INSERT;
		mid_word = 1'b0;
		path_gone = 1'b0;
		word_err = STATUS_OK;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty trie, single-character words, extreme letters
		send_text(REQ_SEARCH, "a");
		send_text(REQ_INSERT, "a");
		send_text(REQ_SEARCH, "a");
		send_text(REQ_INSERT, "zz");
		send_text(REQ_PREFIX, "z");
		send_text(REQ_SEARCH, "z");
		send_text(REQ_UNUSED, "zz");
		send_text(REQ_SEARCH, "ab");
		send_text(REQ_INSERT, "azb");
		send_text(REQ_SEARCH, "az");
		// bad byte just past the letters after an allocation; the node stays
		wbuf[0] = 8'h62;
		wbuf[1] = 8'h7B;
		send_word(REQ_INSERT, 2);
		send_text(REQ_PREFIX, "b");
		send_text(REQ_SEARCH, "b");
		// two bad bytes in one word, the byte extremes
		wbuf[0] = 8'hFF;
		wbuf[1] = 8'h00;
		send_word(REQ_SEARCH, 2);
		// missing path followed by the byte just below the letters
		wbuf[0] = 8'h71;
		wbuf[1] = 8'h60;
		send_word(REQ_PREFIX, 2);
		wbuf[0] = 8'h80;
		send_word(REQ_INSERT, 1);

		gen_mix(100);
		drain();

		// fill the node pool with long fresh words; the sender waits after each one
		while (free_ptr < NODE_COUNT) begin
			for (int i = 0; i < FILL_LEN; i++)
				wbuf[i] = 8'(FIRST_LETTER + $urandom_range(ALPHABET - 1, 0));
			send_word(REQ_INSERT, FILL_LEN);
			keep_word(FILL_LEN);
			drain();
		end

		// full pool: new paths fail, stored words still answer
		gen_mix(80);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d characters, checked %0d results: %0d found, %0d pool full",
			n_items, n_rsp, n_found, n_full);
		$display("%0d bad char, trie grew to %0d of %0d nodes, %0d mismatches",
			n_bad, free_ptr, NODE_COUNT, n_err);
		if (n_err == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
